### rtl/gtg_pkg.sv
// Shared constants, types and tables for the go-to-goal drive command block.
`default_nettype none
package gtg_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_TARGET_X       = 2'd0,
        REG_TARGET_Y       = 2'd1,
        REG_ANGLE_LIMIT    = 2'd2,
        REG_VELOCITY_LIMIT = 2'd3
    } cfg_reg_t;

    localparam int unsigned IN_W  = 128;
    localparam int unsigned OUT_W = 80;
    localparam int unsigned CFG_W = 32;

    // atan2 datapath
    localparam int unsigned OPW          = 34;  // operand width
    localparam int unsigned CW           = 44;  // CORDIC x/y width
    localparam int unsigned MW           = 41;  // normalizing magnitude width
    localparam int unsigned ZW           = 21;  // angle accumulator, Q.16
    localparam int unsigned ANGW         = 18;  // angle result, Q4.13
    localparam int unsigned NORM_EXP     = 40;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned CORDIC_STGS  = CORDIC_STEPS / 2;

    localparam logic signed [ZW-1:0] PI_Q16 = 21'sd205887;
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
        21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32,
        21'sd16, 21'sd8, 21'sd4, 21'sd2
    };

    // Square root
    localparam int unsigned SQRT_STGS = 32;

    // Heading
    localparam int unsigned HEADW = 19;
    localparam logic signed [HEADW-1:0] PI_Q13     = 19'sd25736;
    localparam logic signed [HEADW-1:0] TWO_PI_Q13 = 19'sd51472;
    localparam int unsigned HEAD_DLY = 20;

    // floor(d / 5) == (d * RECIP5) >> 34 for any 32-bit d
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

    localparam int unsigned PIPE_LAT = 37;

    typedef struct packed {
        logic              zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [MW-1:0]     m;
    } norm_t;

    typedef struct packed {
        logic              zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

endpackage
`default_nettype wire

### rtl/go_to_goal_drive_command_core.sv
// Throughput: one word per cycle while the skid register is empty; the depth is set by the 32-stage square root,
// with the two 14-stage atan2 pipelines running alongside it.
// A skid register takes a result word the receiver refuses; input stalls while it is full.
// Reset clears valid bits and loads the register defaults (targets 0, limits 0.4 and 0.3).
`default_nettype none
module go_to_goal_drive_command_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y[95:80], quat_z[111:96], quat_w[127:112]
    input  wire logic [gtg_pkg::IN_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // forward_cmd[30:0], turn_cmd[46:31], goal_distance[78:47], zero pad[79]
    output logic [gtg_pkg::OUT_W-1:0]          m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [gtg_pkg::CFG_W-1:0]     cfg_data
);

    logic signed [31:0] target_x_reg, target_y_reg;
    logic [14:0]        angle_limit_reg;
    logic [30:0]        velocity_limit_reg;

    logic [gtg_pkg::PIPE_LAT-1:0] valid_reg;
    logic                         skid_valid_reg;
    logic [gtg_pkg::OUT_W-1:0]    skid_data_reg;
    logic                         en;

    // stage 1
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [31:0] pwz1_reg, pxy1_reg, pyy1_reg, pzz1_reg;
    // stage 2
    logic [63:0]                   sqx2_reg, sqy2_reg;
    logic signed [gtg_pkg::OPW-1:0] bx2_reg, by2_reg, num2_reg, den2_reg;
    // stage 3
    logic [63:0] rad3_reg;
    // heading delay, stage 17 .. 36
    logic signed [gtg_pkg::HEADW-1:0] head_reg [gtg_pkg::HEAD_DLY];
    // stage 36, 37
    logic [31:0] dist36_reg;
    logic [63:0] prod36_reg;
    logic [30:0] fwd37_reg;
    logic [15:0] turn37_reg;
    logic [31:0] dist37_reg;

    logic signed [31:0] pos_x, pos_y;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic [32:0]        ax, ay;
    logic [64:0]        sq_sum;
    logic signed [gtg_pkg::ANGW-1:0]  bearing, yaw;
    logic signed [gtg_pkg::HEADW-1:0] diff, head_next, lim, turn_next;
    logic [31:0]  root;
    logic [30:0]  fwd_raw, fwd_next;
    logic [gtg_pkg::OUT_W-1:0] out_word;

    assign pos_x  = s_tdata[31:0];
    assign pos_y  = s_tdata[63:32];
    assign quat_x = s_tdata[79:64];
    assign quat_y = s_tdata[95:80];
    assign quat_z = s_tdata[111:96];
    assign quat_w = s_tdata[127:112];

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg       <= '0;
            target_y_reg       <= '0;
            angle_limit_reg    <= 15'd3277;
            velocity_limit_reg <= 31'd19661;
        end
        else if (cfg_we)
        begin
            unique case (gtg_pkg::cfg_reg_t'(cfg_index))
                gtg_pkg::REG_TARGET_X:       target_x_reg       <= cfg_data;
                gtg_pkg::REG_TARGET_Y:       target_y_reg       <= cfg_data;
                gtg_pkg::REG_ANGLE_LIMIT:    angle_limit_reg    <= cfg_data[14:0];
                gtg_pkg::REG_VELOCITY_LIMIT: velocity_limit_reg <= cfg_data[30:0];
            endcase
        end
    end

    always_comb
    begin
        ax = dx1_reg[32] ? -dx1_reg : dx1_reg;
        ay = dy1_reg[32] ? -dy1_reg : dy1_reg;
        sq_sum = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

        diff = {bearing[gtg_pkg::ANGW-1], bearing} - {yaw[gtg_pkg::ANGW-1], yaw};
        priority if (diff > gtg_pkg::PI_Q13)
            head_next = diff - gtg_pkg::TWO_PI_Q13;
        else if (diff < -gtg_pkg::PI_Q13)
            head_next = diff + gtg_pkg::TWO_PI_Q13;
        else
            head_next = diff;

        lim = {4'b0, angle_limit_reg};
        turn_next = head_reg[gtg_pkg::HEAD_DLY-1];
        if (turn_next > lim)
            turn_next = lim;
        if (turn_next < -lim)
            turn_next = -lim;

        fwd_raw  = {1'b0, prod36_reg[63:34]};
        fwd_next = (fwd_raw > velocity_limit_reg) ? velocity_limit_reg : fwd_raw;

        out_word = {1'b0, dist37_reg, turn37_reg, fwd37_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg  <= {target_x_reg[31], target_x_reg} - {pos_x[31], pos_x};
            dy1_reg  <= {target_y_reg[31], target_y_reg} - {pos_y[31], pos_y};
            pwz1_reg <= 32'(quat_w) * 32'(quat_z);
            pxy1_reg <= 32'(quat_x) * 32'(quat_y);
            pyy1_reg <= 32'(quat_y) * 32'(quat_y);
            pzz1_reg <= 32'(quat_z) * 32'(quat_z);

            sqx2_reg <= 64'(ax[31:0]) * 64'(ax[31:0]);
            sqy2_reg <= 64'(ay[31:0]) * 64'(ay[31:0]);
            bx2_reg  <= {dx1_reg[32], dx1_reg};
            by2_reg  <= {dy1_reg[32], dy1_reg};
            num2_reg <= ({{2{pwz1_reg[31]}}, pwz1_reg} + {{2{pxy1_reg[31]}}, pxy1_reg}) <<< 1;
            den2_reg <= 34'sd268435456
                      - (({{2{pyy1_reg[31]}}, pyy1_reg} + {{2{pzz1_reg[31]}}, pzz1_reg}) <<< 1);

            // an overflowed sum saturates; its root is then all ones
            rad3_reg <= sq_sum[64] ? '1 : sq_sum[63:0];

            head_reg[0] <= head_next;
            for (int k = 1; k < gtg_pkg::HEAD_DLY; k++)
            begin
                head_reg[k] <= head_reg[k-1];
            end

            dist36_reg <= root;
            prod36_reg <= 64'(root) * 64'(gtg_pkg::RECIP5);

            fwd37_reg  <= fwd_next;
            turn37_reg <= turn_next[15:0];
            dist37_reg <= dist36_reg;
        end
    end

    gtg_atan2 u_bearing (
        .clk   (clk),
        .en    (en),
        .y_in  (by2_reg),
        .x_in  (bx2_reg),
        .angle (bearing)
    );

    gtg_atan2 u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (num2_reg),
        .x_in  (den2_reg),
        .angle (yaw)
    );

    gtg_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (rad3_reg),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[gtg_pkg::PIPE_LAT-2:0], s_tvalid};
            end
            priority if (skid_valid_reg && m_tready)
                skid_valid_reg <= 1'b0;
            else if (!skid_valid_reg && valid_reg[gtg_pkg::PIPE_LAT-1] && !m_tready)
                skid_valid_reg <= 1'b1;
        end
    end

    // hold the unaccepted result while the pipeline advances
    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && valid_reg[gtg_pkg::PIPE_LAT-1] && !m_tready)
        begin
            skid_data_reg <= out_word;
        end
    end

    assign m_tvalid = skid_valid_reg || valid_reg[gtg_pkg::PIPE_LAT-1];
    assign m_tdata  = skid_valid_reg ? skid_data_reg : out_word;

endmodule
`default_nettype wire

### rtl/gtg_atan2.sv
// Pipelined atan2: normalize, fold into the right half plane, 16 CORDIC steps, round.
`default_nettype none
module gtg_atan2 (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [gtg_pkg::OPW-1:0]    y_in,
    input  wire logic signed [gtg_pkg::OPW-1:0]    x_in,
    output logic signed [gtg_pkg::ANGW-1:0]        angle
);

    function automatic gtg_pkg::norm_t norm_step(gtg_pkg::norm_t a, int unsigned s);
        gtg_pkg::norm_t r;
        r = a;
        if ((a.m >> (gtg_pkg::NORM_EXP - s)) == '0)
        begin
            r.m = a.m << s;
            r.x = a.x <<< s;
            r.y = a.y <<< s;
        end
        return r;
    endfunction

    function automatic gtg_pkg::cord_t cordic_step(gtg_pkg::cord_t a, int unsigned i);
        gtg_pkg::cord_t r;
        r = a;
        if (a.y > 0)
        begin
            r.x = a.x + (a.y >>> i);
            r.y = a.y - (a.x >>> i);
            r.z = a.z + gtg_pkg::ATAN_TAB[i];
        end
        else if (a.y < 0)
        begin
            r.x = a.x - (a.y >>> i);
            r.y = a.y + (a.x >>> i);
            r.z = a.z - gtg_pkg::ATAN_TAB[i];
        end
        return r;
    endfunction

    gtg_pkg::norm_t n1_reg, n2_reg, n3_reg, n4_reg;
    gtg_pkg::norm_t n1_next, n2_next, n3_next, n4_next;
    gtg_pkg::cord_t q_reg, q_next;
    gtg_pkg::cord_t c_reg  [gtg_pkg::CORDIC_STGS];
    gtg_pkg::cord_t c_next [gtg_pkg::CORDIC_STGS];
    logic signed [gtg_pkg::ANGW-1:0] angle_reg, angle_next;

    logic [gtg_pkg::OPW:0] mag_x, mag_y;
    logic signed [gtg_pkg::ZW:0] z_rnd;

    always_comb
    begin
        mag_x = x_in[gtg_pkg::OPW-1] ? (~{1'b1, x_in} + 1'b1) : {1'b0, x_in};
        mag_y = y_in[gtg_pkg::OPW-1] ? (~{1'b1, y_in} + 1'b1) : {1'b0, y_in};
        n1_next.zero = (x_in == '0) && (y_in == '0);
        n1_next.x = {{(gtg_pkg::CW-gtg_pkg::OPW){x_in[gtg_pkg::OPW-1]}}, x_in};
        n1_next.y = {{(gtg_pkg::CW-gtg_pkg::OPW){y_in[gtg_pkg::OPW-1]}}, y_in};
        n1_next.m = (mag_x > mag_y)
                  ? {{(gtg_pkg::MW-gtg_pkg::OPW-1){1'b0}}, mag_x}
                  : {{(gtg_pkg::MW-gtg_pkg::OPW-1){1'b0}}, mag_y};

        n2_next = norm_step(norm_step(n1_reg, 32), 16);
        n3_next = norm_step(norm_step(n2_reg, 8), 4);
        // greedy steps leave m just below the bound; one more doubling crosses it
        n4_next   = norm_step(norm_step(n3_reg, 2), 1);
        n4_next.m = n4_next.m << 1;
        n4_next.x = n4_next.x <<< 1;
        n4_next.y = n4_next.y <<< 1;

        q_next.zero = n4_reg.zero;
        q_next.x = n4_reg.x;
        q_next.y = n4_reg.y;
        q_next.z = '0;
        if (n4_reg.x < 0)
        begin
            q_next.z = (n4_reg.y >= 0) ? gtg_pkg::PI_Q16 : -gtg_pkg::PI_Q16;
            q_next.x = -n4_reg.x;
            q_next.y = -n4_reg.y;
        end

        for (int c = 0; c < gtg_pkg::CORDIC_STGS; c++)
        begin
            c_next[c] = cordic_step(cordic_step((c == 0) ? q_reg : c_reg[(c == 0) ? 0 : c-1],
                                                2*c), 2*c+1);
        end

        z_rnd = {c_reg[gtg_pkg::CORDIC_STGS-1].z[gtg_pkg::ZW-1],
                 c_reg[gtg_pkg::CORDIC_STGS-1].z} + 22'sd4;
        angle_next = c_reg[gtg_pkg::CORDIC_STGS-1].zero ? '0
                   : $signed(z_rnd[gtg_pkg::ANGW+2:3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            n3_reg    <= n3_next;
            n4_reg    <= n4_next;
            q_reg     <= q_next;
            for (int c = 0; c < gtg_pkg::CORDIC_STGS; c++)
            begin
                c_reg[c] <= c_next[c];
            end
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

### rtl/gtg_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
`default_nettype none
module gtg_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic [31:0]      root
);

    logic [63:0] rem_reg  [gtg_pkg::SQRT_STGS];
    logic [63:0] res_reg  [gtg_pkg::SQRT_STGS];
    logic [63:0] rem_next [gtg_pkg::SQRT_STGS];
    logic [63:0] res_next [gtg_pkg::SQRT_STGS];
    logic [63:0] rem_cur  [gtg_pkg::SQRT_STGS];
    logic [63:0] res_cur  [gtg_pkg::SQRT_STGS];
    logic [63:0] trial    [gtg_pkg::SQRT_STGS];
    logic [63:0] bitv     [gtg_pkg::SQRT_STGS];

    always_comb
    begin
        for (int j = 0; j < gtg_pkg::SQRT_STGS; j++)
        begin
            rem_cur[j] = (j == 0) ? radicand : rem_reg[(j == 0) ? 0 : j-1];
            res_cur[j] = (j == 0) ? 64'd0 : res_reg[(j == 0) ? 0 : j-1];
            bitv[j]    = 64'd1 << (62 - 2*j);
            trial[j]   = res_cur[j] + bitv[j];
            if (rem_cur[j] >= trial[j])
            begin
                rem_next[j] = rem_cur[j] - trial[j];
                res_next[j] = (res_cur[j] >> 1) + bitv[j];
            end
            else
            begin
                rem_next[j] = rem_cur[j];
                res_next[j] = res_cur[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < gtg_pkg::SQRT_STGS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                res_reg[j] <= res_next[j];
            end
        end
    end

    assign root = res_reg[gtg_pkg::SQRT_STGS-1][31:0];

endmodule
`default_nettype wire
